// ===== design/chs_pkg.sv =====
// Shared types, constants and the arctangent table for the compass heading unit.
`default_nettype none

package chs_pkg;

	// Default number of CORDIC cells and the largest count the table supports.
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_TABLE_LEN   = 24;

	// Input and output field widths.
	localparam int IN_W  = 16;
	localparam int ABS_W = IN_W + 1;
	localparam int DEG_W = 9;

	// CORDIC datapath: prescale by 2^14, magnitudes stay below 2^31 after gain.
	localparam int PRESCALE_BITS = 14;
	localparam int CW            = 34;

	// Angle accumulator in degrees with 16 fractional bits.
	localparam int FRAC_BITS = 16;
	localparam int ZW        = 26;
	localparam int AW        = 23;
	localparam int HW        = 25;

	localparam logic [AW-1:0] Q90  = AW'(90 * 65536);
	localparam logic [HW-1:0] Q180 = HW'(180 * 65536);
	localparam logic [HW-1:0] Q360 = HW'(360 * 65536);

	// Fixed headings for the axis cases.
	localparam logic [DEG_W-1:0] DEG_ZERO = 9'd0;
	localparam logic [DEG_W-1:0] DEG_90   = 9'd90;
	localparam logic [DEG_W-1:0] DEG_180  = 9'd180;
	localparam logic [DEG_W-1:0] DEG_270  = 9'd270;
	localparam logic [DEG_W-1:0] DEG_MAX  = 9'd359;

	// Word handed from one CORDIC cell to the next.
	typedef struct packed {
		logic                    axis;
		logic [DEG_W-1:0]        axis_deg;
		logic                    x_neg;
		logic                    y_neg;
		logic signed [CW-1:0]    cx;
		logic signed [CW-1:0]    cy;
		logic signed [ZW-1:0]    z;
	} chs_word_t;

	// atan(2^-i) in degrees times 65536, rounded to nearest.
	function automatic logic signed [ZW-1:0] chs_atan_q16(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:       r = ZW'(2949120);
			1:       r = ZW'(1740967);
			2:       r = ZW'(919879);
			3:       r = ZW'(466945);
			4:       r = ZW'(234379);
			5:       r = ZW'(117304);
			6:       r = ZW'(58666);
			7:       r = ZW'(29335);
			8:       r = ZW'(14668);
			9:       r = ZW'(7334);
			10:      r = ZW'(3667);
			11:      r = ZW'(1833);
			12:      r = ZW'(917);
			13:      r = ZW'(458);
			14:      r = ZW'(229);
			15:      r = ZW'(115);
			16:      r = ZW'(57);
			17:      r = ZW'(29);
			18:      r = ZW'(14);
			19:      r = ZW'(7);
			20:      r = ZW'(4);
			21:      r = ZW'(2);
			22:      r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/chs_xy_if.sv =====
// Channel that carries one x/y field sample word.
`default_nettype none

interface chs_xy_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  x_component;
	logic signed [15:0]  y_component;

	modport source (output valid, output x_component, output y_component, input ready);
	modport sink (input valid, input x_component, input y_component, output ready);
endinterface

`default_nettype wire

// ===== design/chs_hdg_if.sv =====
// Channel that carries one heading word.
`default_nettype none

interface chs_hdg_if;
	logic        valid;
	logic        ready;
	logic [8:0]  heading_deg;

	modport source (output valid, output heading_deg, input ready);
	modport sink (input valid, input heading_deg, output ready);
endinterface

`default_nettype wire

// ===== design/chs_cell.sv =====
// One vectoring CORDIC iteration with its own pipeline register.
`default_nettype none

module chs_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	input  chs_pkg::chs_word_t up_word,
	output logic               up_ready,
	output logic               dn_valid,
	output chs_pkg::chs_word_t dn_word,
	input  logic               dn_ready
);
	import chs_pkg::*;

	logic                 valid_s1;
	chs_word_t            word_s1;
	chs_word_t            word_nx;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	// The cell takes a word when it is empty or its word moves on.
	assign up_ready = !valid_s1 || dn_ready;

	// Rotate toward the x axis; the shifts round toward minus infinity.
	always_comb begin
		word_nx = up_word;
		dx      = up_word.cy >>> STEP;
		dy      = up_word.cx >>> STEP;
		if (up_word.cy > 0) begin
			word_nx.cx = up_word.cx + dx;
			word_nx.cy = up_word.cy - dy;
			word_nx.z  = up_word.z + chs_atan_q16(STEP);
		end else begin
			word_nx.cx = up_word.cx - dx;
			word_nx.cy = up_word.cy + dy;
			word_nx.z  = up_word.z - chs_atan_q16(STEP);
		end
	end

	// Valid bit is control state and is reset; the payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= word_nx;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

endmodule

`default_nettype wire

// ===== design/chs_fold.sv =====
// Quadrant fold, degree truncation and the output register.
`default_nettype none

module chs_fold (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	input  chs_pkg::chs_word_t up_word,
	output logic               up_ready,
	chs_hdg_if.source          hdg
);
	import chs_pkg::*;

	logic             valid_s1;
	logic [DEG_W-1:0] heading_s1;
	logic [AW-1:0]    a;
	logic [HW-1:0]    h;
	logic [DEG_W-1:0] deg;

	assign up_ready = !valid_s1 || hdg.ready;

	// Clamp the first-quadrant angle, fold in the quadrant, keep whole degrees; axis words take their fixed heading.
	always_comb begin
		if (up_word.z < 0) begin
			a = '0;
		end else if (up_word.z > $signed({{(ZW-AW){1'b0}}, Q90})) begin
			a = Q90;
		end else begin
			a = up_word.z[AW-1:0];
		end
		if (!up_word.x_neg && up_word.y_neg) begin
			h = HW'(a);
		end else if (up_word.x_neg && up_word.y_neg) begin
			h = Q180 - HW'(a);
		end else if (up_word.x_neg) begin
			h = Q180 + HW'(a);
		end else begin
			h = Q360 - HW'(a);
		end
		if (up_word.axis) begin
			deg = up_word.axis_deg;
		end else if (h[HW-1:FRAC_BITS] > DEG_MAX) begin
			deg = DEG_MAX;
		end else begin
			deg = h[HW-1:FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			heading_s1 <= deg;
		end
	end

	assign hdg.valid       = valid_s1;
	assign hdg.heading_deg = heading_s1;

endmodule

`default_nettype wire

// ===== design/compass_heading_from_xy_unit.sv =====
// Each sample word is registered in every CORDIC cell, then in the fold register.
// Throughput: one word per cycle while the output is not stalled; a chain of CORDIC
// cells, one iteration each, sets it. Every cell has its own valid bit, so a stalled
// output stops only the words behind it and empty cells still take new words.
// Reset (arst_n low) clears all valid bits at once; no word is in flight afterwards.
`default_nettype none

module compass_heading_from_xy_unit #(
	parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	chs_xy_if.sink    xy,
	chs_hdg_if.source hdg
);
	import chs_pkg::*;

	localparam int PAD_W = CW - ABS_W - PRESCALE_BITS;

	chs_word_t        word_in;
	chs_word_t        word_c  [0:CORDIC_STEPS];
	logic             valid_c [0:CORDIC_STEPS];
	logic             ready_c [0:CORDIC_STEPS];
	logic [ABS_W-1:0] ax;
	logic [ABS_W-1:0] ay;
	logic             x_zero;
	logic             y_zero;

	// Magnitudes, signs and the axis cases of the incoming word.
	always_comb begin
		x_zero = (xy.x_component == '0);
		y_zero = (xy.y_component == '0);
		ax = xy.x_component[IN_W-1] ? (ABS_W'(0) - {xy.x_component[IN_W-1], xy.x_component})
		                            : {1'b0, xy.x_component};
		ay = xy.y_component[IN_W-1] ? (ABS_W'(0) - {xy.y_component[IN_W-1], xy.y_component})
		                            : {1'b0, xy.y_component};
		word_in.x_neg = xy.x_component[IN_W-1];
		word_in.y_neg = xy.y_component[IN_W-1];
		word_in.axis  = x_zero || y_zero;
		if (x_zero) begin
			word_in.axis_deg = xy.y_component[IN_W-1] ? DEG_90 : (y_zero ? DEG_ZERO : DEG_270);
		end else begin
			word_in.axis_deg = xy.x_component[IN_W-1] ? DEG_180 : DEG_ZERO;
		end
		word_in.cx = $signed({{PAD_W{1'b0}}, ax, {PRESCALE_BITS{1'b0}}});
		word_in.cy = $signed({{PAD_W{1'b0}}, ay, {PRESCALE_BITS{1'b0}}});
		word_in.z  = '0;
	end

	assign word_c[0]  = word_in;
	assign valid_c[0] = xy.valid;
	assign xy.ready   = ready_c[0];

	// Chain of CORDIC cells, one iteration per cell.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		chs_cell #(
			.STEP (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[i]),
			.up_word  (word_c[i]),
			.up_ready (ready_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_word  (word_c[i+1]),
			.dn_ready (ready_c[i+1])
		);
	end

	// Quadrant fold and output register.
	chs_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[CORDIC_STEPS]),
		.up_word  (word_c[CORDIC_STEPS]),
		.up_ready (ready_c[CORDIC_STEPS]),
		.hdg      (hdg)
	);

endmodule

`default_nettype wire

// ===== design/chs_checker.sv =====
// Port-level checks for the compass heading unit and their binding.
`default_nettype none

module chs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [8:0] heading_deg
);

	// A heading word never leaves the range of a compass.
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading_deg <= 9'd359))
		else $error("heading word above 359");

	// When the output is taken, every cell can move, so input is ready.
	a_ready_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is drained");

	// A waiting heading word stays on the port until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("heading word dropped while stalled");

	// An empty unit never shows a word in the cycle after reset ends.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("heading word present right after reset");

endmodule

bind compass_heading_from_xy_unit chs_checker u_chs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (xy.valid),
	.in_ready    (xy.ready),
	.out_valid   (hdg.valid),
	.out_ready   (hdg.ready),
	.heading_deg (hdg.heading_deg)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the compass heading unit: directed and random samples.
`timescale 1ns / 100ps

module testbench;
	import chs_pkg::*;

	localparam int CORDIC_STEPS   = CORDIC_STEPS_DEF;
	localparam int LATENCY        = CORDIC_STEPS + 1;
	localparam int RANDOM_SAMPLES = 1250;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 100;

	// atan(2^-i) in degrees, 16 fractional bits.
	localparam longint ATAN_DEG_Q16 [ATAN_TABLE_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// Receiver stall patterns.
	typedef enum int {RX_OPEN, RX_SPARSE, RX_LONG, RX_TOGGLE} rx_mode_e;

	// A sample word waiting to be sent; drain_first holds it until all headings are back.
	typedef struct {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		bit                     drain_first;
	} field_sample_t;

	// A heading word still owed by the block.
	typedef struct {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic [DEG_W-1:0]       heading;
	} heading_due_t;

	logic clk;
	logic arst_n;

	chs_xy_if  xy ();
	chs_hdg_if hdg ();

	compass_heading_from_xy_unit #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.xy    (xy.sink),
		.hdg   (hdg.source)
	);

	field_sample_t samples_pending [$];
	heading_due_t  headings_due [$];

	int mismatch_count = 0;
	int samples_sent   = 0;
	int headings_seen  = 0;
	int directed_count = 0;
	int random_count   = 0;
	int drain_pauses   = 0;
	int mode_changes   = 0;
	int idle_cycles    = 0;

	int       burst_left = 1;
	int       gap_left   = 0;
	rx_mode_e stall_mode = RX_OPEN;
	int       mode_left  = 0;
	int       stall_left = 0;

	// Clockwise heading of one field sample, worked out with a vectoring CORDIC.
	function automatic logic [DEG_W-1:0] heading_from_field(logic signed [IN_W-1:0] x,
			logic signed [IN_W-1:0] y);
		longint ax, ay, cx, cy, dx, dy, z, h, deg;
		int i;
		if (x == 0) begin
			deg = (y < 0) ? longint'(DEG_90) : (y > 0) ? longint'(DEG_270) : longint'(DEG_ZERO);
		end else if (y == 0) begin
			deg = (x < 0) ? longint'(DEG_180) : longint'(DEG_ZERO);
		end else begin
			ax = longint'(x);
			ay = longint'(y);
			if (ax < 0) ax = -ax;
			if (ay < 0) ay = -ay;
			cx = ax <<< PRESCALE_BITS;
			cy = ay <<< PRESCALE_BITS;
			z = 0;
			// Rotate toward the x axis, summing the angle turned through.
			for (i = 0; i < CORDIC_STEPS && i < ATAN_TABLE_LEN; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy > 0) begin
					cx += dx;
					cy -= dy;
					z += ATAN_DEG_Q16[i];
				end else begin
					cx -= dx;
					cy += dy;
					z -= ATAN_DEG_Q16[i];
				end
			end
			if (z < 0) z = 0;
			if (z > 90 * 65536) z = 90 * 65536;
			// Fold the first-quadrant angle into the right quadrant.
			if (x > 0 && y < 0) h = z;
			else if (x < 0 && y < 0) h = 180 * 65536 - z;
			else if (x < 0) h = 180 * 65536 + z;
			else h = 360 * 65536 - z;
			if (h < 0) h = 0;
			deg = h / 65536;
		end
		if (deg > longint'(DEG_MAX)) deg = longint'(DEG_MAX);
		if (deg < 0) deg = 0;
		return deg[DEG_W-1:0];
	endfunction

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic flag_mismatch(string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic add_sample(int x, int y, bit drain_first);
		field_sample_t s;
		s.x = 16'(x);
		s.y = 16'(y);
		s.drain_first = drain_first;
		samples_pending.push_back(s);
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sender: presents sample words in bursts with random gaps in between.
	always @(posedge clk) begin
		logic next_valid;
		field_sample_t nxt;
		heading_due_t due;
		if (!arst_n) begin
			xy.valid <= 1'b0;
		end else begin
			next_valid = xy.valid;
			if (xy.valid && xy.ready) begin
				due.x = xy.x_component;
				due.y = xy.y_component;
				due.heading = heading_from_field(xy.x_component, xy.y_component);
				headings_due.push_back(due);
				samples_sent++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (samples_pending.size() > 0 &&
						!(samples_pending[0].drain_first && headings_due.size() > 0)) begin
					nxt = samples_pending.pop_front();
					if (nxt.drain_first) drain_pauses++;
					xy.x_component <= nxt.x;
					xy.y_component <= nxt.y;
					next_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
						if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(20, 40);
					end
				end
			end
			xy.valid <= next_valid;
		end
	end

	// Receiver: checks each heading word and drives ready from a changing stall pattern.
	always @(posedge clk) begin
		logic next_ready;
		heading_due_t want;
		if (!arst_n) begin
			hdg.ready <= 1'b0;
		end else begin
			if (hdg.valid && hdg.ready) begin
				headings_seen++;
				if (headings_due.size() == 0) begin
					flag_mismatch($sformatf("heading %0d arrived with none outstanding",
						hdg.heading_deg));
				end else begin
					want = headings_due.pop_front();
					if (hdg.heading_deg !== want.heading)
						flag_mismatch($sformatf("x=%0d y=%0d heading_deg got %0d want %0d",
							want.x, want.y, hdg.heading_deg, want.heading));
				end
			end
			if (mode_left == 0) begin
				stall_mode = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
				mode_changes++;
			end else begin
				mode_left--;
			end
			case (stall_mode)
				RX_OPEN: begin
					next_ready = 1'b1;
				end
				RX_SPARSE: begin
					next_ready = ($urandom_range(0, 3) != 0);
				end
				RX_LONG: begin
					if (stall_left > 0) begin
						stall_left--;
						next_ready = 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(1, 24);
						next_ready = 1'b0;
					end else begin
						next_ready = 1'b1;
					end
				end
				default: begin
					next_ready = ~hdg.ready;
				end
			endcase
			hdg.ready <= next_ready;
		end
	end

	// Counts cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (xy.valid && xy.ready) || (hdg.valid && hdg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Watchdog: ends a run that has stopped making progress.
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles with no word moving", WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		int kind;
		int x;
		int y;
		xy.valid = 1'b0;
		xy.x_component = '0;
		xy.y_component = '0;
		hdg.ready = 1'b0;
		arst_n = 1'b0;

		// Directed: axis cases, both zero, the wrap near 360 and the field extremes.
		add_sample(0, 0, 1'b0);
		add_sample(1, 0, 1'b0);
		add_sample(32767, 0, 1'b0);
		add_sample(-1, 0, 1'b0);
		add_sample(-32768, 0, 1'b0);
		add_sample(0, -1, 1'b0);
		add_sample(0, -32768, 1'b0);
		add_sample(0, 1, 1'b0);
		add_sample(0, 32767, 1'b0);
		add_sample(32767, 1, 1'b0);
		add_sample(32767, 2, 1'b0);
		add_sample(32767, -1, 1'b0);
		add_sample(-32768, 1, 1'b0);
		add_sample(-32768, -1, 1'b0);
		add_sample(32767, 32767, 1'b0);
		add_sample(32767, -32768, 1'b0);
		add_sample(-32768, 32767, 1'b0);
		add_sample(-32768, -32768, 1'b0);
		add_sample(1, 1, 1'b0);
		add_sample(1, -1, 1'b0);
		add_sample(-1, 1, 1'b0);
		add_sample(-1, -1, 1'b0);
		add_sample(1, 32767, 1'b0);
		add_sample(-1, -32768, 1'b0);
		directed_count = samples_pending.size();

		// Random: full range, weighted toward small values, axes, diagonals, the wrap, power-of-two ratios and extreme x.
		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			kind = $urandom_range(0, 9);
			x = int'($signed(16'($urandom)));
			y = int'($signed(16'($urandom)));
			case (kind)
				4: begin
					x = int'($urandom_range(0, 16)) - 8;
					y = int'($urandom_range(0, 16)) - 8;
				end
				5: begin
					if ($urandom_range(0, 1) == 1) x = 0;
					else y = 0;
				end
				6: begin
					if (x == -32768) x = -32767;
					y = ($urandom_range(0, 1) == 1) ? x : -x;
				end
				7: begin
					x = $urandom_range(1000, 32767);
					y = $urandom_range(1, 40);
				end
				8: begin
					y = x >>> $urandom_range(0, 15);
					if ($urandom_range(0, 1) == 1) y = -y;
				end
				9: begin
					case ($urandom_range(0, 6))
						0: x = -32768;
						1: x = -32767;
						2: x = -1;
						3: x = 0;
						4: x = 1;
						5: x = 32766;
						default: x = 32767;
					endcase
				end
				default: begin
				end
			endcase
			add_sample(x, y, (n == 0) || (n == RANDOM_SAMPLES / 2) ||
				($urandom_range(0, 299) == 0));
		end
		random_count = samples_pending.size() - directed_count;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word to go in and every heading to come back.
		while (samples_pending.size() > 0 || xy.valid)
			@(posedge clk);
		while (headings_due.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("covered %0d samples (%0d directed, %0d random), %0d headings compared",
			samples_sent, directed_count, random_count, headings_seen);
		$display("sender drained the pipeline %0d times; receiver switched stall pattern %0d times",
			drain_pauses, mode_changes);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
